[src/kpvt_pkg.sv]
// Shared types, codes and saturation helpers for the position/velocity tracker.
// No dependencies; every other file in src imports this package.
`default_nettype none

package kpvt_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_PREDICT = 2'd1;
    localparam logic [1:0] CMD_UPDATE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_VAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_VAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODER_VAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL    = 3'd4;

    localparam logic signed [65:0] COV_HI = 66'sd140737488355327;
    localparam logic signed [65:0] COV_LO = -66'sd140737488355328;
    localparam logic signed [65:0] S32_HI = 66'sd2147483647;
    localparam logic signed [65:0] S32_LO = -66'sd2147483648;

    typedef struct packed {
        logic [1:0]         command;
        logic [23:0]        time_step;
        logic signed [31:0] cam_dist;
        logic signed [31:0] enc_dist;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] position_estimate;
        logic signed [31:0] velocity_estimate;
        logic               saturated;
    } t_out_word;

    typedef enum logic [1:0] {SH_0, SH_16, SH_17, SH_34} t_shift;

    typedef enum logic [3:0] {
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
        ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6
    } t_step;

    typedef struct packed {
        logic  load;
        logic  init;
        logic  prep;
        logic  start;
        logic  wb;
        logic  emit;
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       s_zero;
        logic       unit_done;
    } t_dp_status;

    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        if (x > COV_HI) begin
            sat48 = COV_HI[47:0];
        end else if (x < COV_LO) begin
            sat48 = COV_LO[47:0];
        end else begin
            sat48 = x[47:0];
        end
    endfunction

    function automatic logic ovf48(input logic signed [65:0] x);
        ovf48 = (x > COV_HI) || (x < COV_LO);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > S32_HI) begin
            sat32 = S32_HI[31:0];
        end else if (x < S32_LO) begin
            sat32 = S32_LO[31:0];
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    function automatic logic ovf32(input logic signed [65:0] x);
        ovf32 = (x > S32_HI) || (x < S32_LO);
    endfunction

endpackage

`default_nettype wire

[src/kpvt_arith.sv]
// Shared multi-cycle unit: rounded product with shift, or rounded product over divisor.
// 64x16 multiplier in four 16-bit passes, restoring divider one bit a cycle. Uses kpvt_pkg.
`default_nettype none

module kpvt_arith (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_op_a,
    input  wire logic signed [63:0] i_op_b,
    input  wire logic signed [63:0] i_divisor,
    input  wire logic               i_div,
    input  wire logic               i_wide,
    input  wire kpvt_pkg::t_shift   i_shift,
    output logic                    o_done,
    output logic signed [63:0]      o_result,
    output logic                    o_clamp
);
    import kpvt_pkg::*;

    typedef enum logic [2:0] {A_IDLE, A_MUL, A_BIAS, A_DIV, A_FIN} t_astate;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    t_astate             r_state;
    logic [63:0]         r_ma;
    logic [63:0]         r_mb;
    logic [127:0]        r_acc;
    logic [63:0]         r_rem;
    logic [63:0]         r_mc;
    logic [6:0]          r_cnt;
    logic                r_neg;
    logic                r_div;
    logic                r_wide;
    t_shift              r_shift;
    logic                r_done;
    logic signed [63:0]  r_result;
    logic                r_clamp;

    logic [79:0]  w_prod;
    logic [127:0] w_acc_mul;
    logic [127:0] w_bias;
    logic [127:0] w_biased;
    logic [127:0] w_shifted;
    logic [64:0]  w_rem2;
    logic         w_ge;
    logic [64:0]  w_rem_sub;
    logic [127:0] w_lim;
    logic         w_over;
    logic [63:0]  w_mag;

    always_comb begin
        w_prod    = r_ma * r_mb[63:48];
        w_acc_mul = {r_acc[111:0], 16'b0} + {48'b0, w_prod};
        if (r_div) begin
            w_bias = {65'b0, r_mc[63:1]};
        end else begin
            case (r_shift)
                SH_16:   w_bias = 128'd32768;
                SH_17:   w_bias = 128'd65536;
                SH_34:   w_bias = 128'd8589934592;
                default: w_bias = 128'd0;
            endcase
        end
        w_biased = r_acc + w_bias;
        case (r_shift)
            SH_16:   w_shifted = w_biased >> 16;
            SH_17:   w_shifted = w_biased >> 17;
            SH_34:   w_shifted = w_biased >> 34;
            default: w_shifted = w_biased;
        endcase
        w_rem2    = {r_rem, r_acc[127]};
        w_ge      = w_rem2 >= {1'b0, r_mc};
        w_rem_sub = w_rem2 - {1'b0, r_mc};
        if (r_wide) begin
            w_lim = 128'h4000_0000_0000_0000;
        end else if (r_neg) begin
            w_lim = 128'h8000_0000_0000;
        end else begin
            w_lim = 128'h7FFF_FFFF_FFFF;
        end
        w_over = r_acc > w_lim;
        w_mag  = w_over ? w_lim[63:0] : r_acc[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_ma    <= mag64(i_op_a);
                        r_mb    <= mag64(i_op_b);
                        r_mc    <= mag64(i_divisor);
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_neg   <= i_op_a[63] ^ i_op_b[63] ^ (i_div & i_divisor[63]);
                        r_div   <= i_div;
                        r_wide  <= i_wide;
                        r_shift <= i_shift;
                        r_state <= A_MUL;
                    end
                end
                A_MUL: begin
                    r_acc <= w_acc_mul;
                    r_mb  <= {r_mb[47:0], 16'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= A_BIAS;
                    end
                end
                A_BIAS: begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    if (r_div) begin
                        r_acc   <= w_biased;
                        r_state <= A_DIV;
                    end else begin
                        r_acc   <= w_shifted;
                        r_state <= A_FIN;
                    end
                end
                A_DIV: begin
                    r_acc <= {r_acc[126:0], w_ge};
                    r_rem <= w_ge ? w_rem_sub[63:0] : w_rem2[63:0];
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    r_result <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                    r_clamp  <= w_over;
                    r_done   <= 1'b1;
                    r_state  <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;
    assign o_clamp  = r_clamp;

endmodule

`default_nettype wire

[src/kpvt_datapath.sv]
// Tracker datapath: config registers, state, covariance, input and output words.
// Runs the predict and update steps on kpvt_arith under controller commands. Uses kpvt_pkg.
`default_nettype none

module kpvt_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [kpvt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kpvt_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire kpvt_pkg::t_in_word            i_in_data,
    input  wire kpvt_pkg::t_dp_cmd             i_cmd,
    output kpvt_pkg::t_dp_status               o_status,
    output kpvt_pkg::t_out_word                o_out_data
);
    import kpvt_pkg::*;

    logic [31:0]        r_accel_var;
    logic [31:0]        r_camera_var;
    logic [31:0]        r_encoder_var;
    logic signed [31:0] r_init_pos;
    logic signed [31:0] r_init_vel;

    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [47:0] r_cov [4];
    logic signed [47:0] r_tmp;
    logic signed [63:0] r_tt;
    logic signed [63:0] r_u;
    logic signed [33:0] r_y;
    logic signed [50:0] r_s;
    logic               r_flag;
    t_in_word           r_in;
    t_out_word          r_out;

    logic signed [31:0] n_pos;
    logic signed [31:0] n_vel;
    logic signed [47:0] n_cov [4];
    logic signed [47:0] n_tmp;
    logic signed [63:0] n_tt;
    logic signed [63:0] n_u;
    logic               n_flag;

    logic signed [63:0] w_op_a;
    logic signed [63:0] w_op_b;
    logic               w_div;
    logic               w_wide;
    t_shift             w_shift;
    logic               w_done;
    logic signed [63:0] w_m;
    logic               w_clamp;

    logic signed [32:0] w_dsum;
    logic signed [32:0] w_z;
    logic signed [33:0] w_y;
    logic [32:0]        w_rsum;
    logic [47:0]        w_r;
    logic signed [50:0] w_s;

    logic signed [65:0] w_t66;
    logic signed [65:0] w_x1;
    logic signed [65:0] w_x2;
    logic signed [65:0] w_x3;
    logic signed [47:0] w_sb;
    logic signed [47:0] w_sc;
    logic signed [47:0] w_k;
    logic signed [47:0] w_ku;

    always_comb begin
        w_t66   = 66'(signed'({1'b0, r_in.time_step}));
        w_div   = 1'b0;
        w_wide  = 1'b1;
        w_shift = SH_16;
        w_op_a  = 64'(r_vel);
        w_op_b  = w_t66[63:0];
        case (i_cmd.step)
            ST_P1: begin
                w_op_a = 64'(r_vel);
            end
            ST_P2: begin
                w_op_a = 64'(r_cov[3]);
                w_wide = 1'b0;
            end
            ST_P3: begin
                w_op_a = 64'(r_tmp);
                w_wide = 1'b0;
            end
            ST_P4: begin
                w_op_a  = w_t66[63:0];
                w_shift = SH_0;
            end
            ST_P5: begin
                w_op_a = r_tt;
                w_op_b = 64'(signed'({1'b0, r_accel_var}));
            end
            ST_P6: begin
                w_op_a  = r_u;
                w_op_b  = r_tt;
                w_shift = SH_34;
            end
            ST_P7: begin
                w_op_a  = r_u;
                w_shift = SH_17;
            end
            ST_U1: begin
                w_div  = 1'b1;
                w_op_a = 64'(r_cov[0]);
                w_op_b = 64'(r_y);
            end
            ST_U2: begin
                w_div  = 1'b1;
                w_op_a = 64'(r_cov[2]);
                w_op_b = 64'(r_y);
            end
            ST_U3: begin
                w_div  = 1'b1;
                w_op_a = 64'(r_cov[2]);
                w_op_b = 64'(r_cov[1]);
            end
            ST_U4: begin
                w_div  = 1'b1;
                w_op_a = 64'(r_cov[0]);
                w_op_b = 64'(r_cov[1]);
            end
            ST_U5: begin
                w_div  = 1'b1;
                w_op_a = 64'(r_cov[2]);
                w_op_b = 64'(r_cov[0]);
            end
            default: begin
                w_div  = 1'b1;
                w_op_a = 64'(r_cov[0]);
                w_op_b = 64'(r_cov[0]);
            end
        endcase
    end

    kpvt_arith u_arith (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.start),
        .i_op_a    (w_op_a),
        .i_op_b    (w_op_b),
        .i_divisor (64'(r_s)),
        .i_div     (w_div),
        .i_wide    (w_wide),
        .i_shift   (w_shift),
        .o_done    (w_done),
        .o_result  (w_m),
        .o_clamp   (w_clamp)
    );

    always_comb begin
        w_dsum = 33'(r_in.cam_dist) + 33'(r_in.enc_dist);
        w_z    = w_dsum >>> 1;
        w_y    = 34'(w_z) - 34'(r_pos);
        w_rsum = {1'b0, r_camera_var} + {1'b0, r_encoder_var};
        w_r    = {w_rsum[32:1], 16'b0};
        w_s    = 51'(r_cov[0]) + signed'({3'b0, w_r});
    end

    always_comb begin
        n_pos  = r_pos;
        n_vel  = r_vel;
        n_cov  = r_cov;
        n_tmp  = r_tmp;
        n_tt   = r_tt;
        n_u    = r_u;
        n_flag = r_flag | w_clamp;
        w_x1   = '0;
        w_x2   = '0;
        w_x3   = '0;
        w_sb   = '0;
        w_sc   = '0;
        w_k    = sat48(66'(w_m));
        w_ku   = sat48(66'(r_u));
        case (i_cmd.step)
            ST_P1, ST_U1: begin
                w_x1   = 66'(r_pos) + 66'(w_m);
                n_pos  = sat32(w_x1);
                n_flag = n_flag | ovf32(w_x1);
            end
            ST_U2: begin
                w_x1   = 66'(r_vel) + 66'(w_m);
                n_vel  = sat32(w_x1);
                n_flag = n_flag | ovf32(w_x1);
            end
            ST_P2: begin
                w_x1     = 66'(r_cov[1]) + 66'(w_m);
                w_x2     = 66'(r_cov[2]) + 66'(w_m);
                w_sb     = sat48(w_x1);
                w_sc     = sat48(w_x2);
                w_x3     = 66'(w_sb) + 66'(r_cov[2]);
                n_cov[1] = w_sb;
                n_cov[2] = w_sc;
                n_tmp    = sat48(w_x3);
                n_flag   = n_flag | ovf48(w_x1) | ovf48(w_x2) | ovf48(w_x3);
            end
            ST_P3: begin
                w_x1     = 66'(r_cov[0]) + 66'(w_m);
                n_cov[0] = sat48(w_x1);
                n_flag   = n_flag | ovf48(w_x1);
            end
            ST_P4: begin
                n_tt = w_m;
            end
            ST_P5: begin
                n_u = w_m;
            end
            ST_P6: begin
                w_x1     = 66'(r_cov[0]) + 66'(w_k);
                n_cov[0] = sat48(w_x1);
                n_flag   = n_flag | ovf48(66'(w_m)) | ovf48(w_x1);
            end
            ST_P7: begin
                w_x1     = 66'(r_cov[1]) + 66'(w_k);
                w_x2     = 66'(r_cov[2]) + 66'(w_k);
                w_x3     = 66'(r_cov[3]) + 66'(w_ku);
                n_cov[1] = sat48(w_x1);
                n_cov[2] = sat48(w_x2);
                n_cov[3] = sat48(w_x3);
                n_flag   = n_flag | ovf48(66'(w_m)) | ovf48(66'(r_u)) | ovf48(w_x1)
                         | ovf48(w_x2) | ovf48(w_x3);
            end
            ST_U3: begin
                w_x1     = 66'(r_cov[3]) - 66'(w_m);
                n_cov[3] = sat48(w_x1);
                n_flag   = n_flag | ovf48(w_x1);
            end
            ST_U4: begin
                w_x1     = 66'(r_cov[1]) - 66'(w_m);
                n_cov[1] = sat48(w_x1);
                n_flag   = n_flag | ovf48(w_x1);
            end
            ST_U5: begin
                w_x1     = 66'(r_cov[2]) - 66'(w_m);
                n_cov[2] = sat48(w_x1);
                n_flag   = n_flag | ovf48(w_x1);
            end
            default: begin
                w_x1     = 66'(r_cov[0]) - 66'(w_m);
                n_cov[0] = sat48(w_x1);
                n_flag   = n_flag | ovf48(w_x1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_var   <= 32'd65536;
            r_camera_var  <= 32'd6554;
            r_encoder_var <= 32'd13107;
            r_init_pos    <= '0;
            r_init_vel    <= '0;
            r_pos         <= '0;
            r_vel         <= '0;
            r_cov[0]      <= 48'sh1_0000_0000;
            r_cov[1]      <= '0;
            r_cov[2]      <= '0;
            r_cov[3]      <= 48'sh1_0000_0000;
            r_flag        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ACCEL_VAR:   r_accel_var   <= i_cfg_data;
                    REG_CAMERA_VAR:  r_camera_var  <= i_cfg_data;
                    REG_ENCODER_VAR: r_encoder_var <= i_cfg_data;
                    REG_INIT_POS:    r_init_pos    <= i_cfg_data;
                    REG_INIT_VEL:    r_init_vel    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_flag <= 1'b0;
            end else if (i_cmd.init) begin
                r_pos    <= r_init_pos;
                r_vel    <= r_init_vel;
                r_cov[0] <= 48'sh1_0000_0000;
                r_cov[1] <= '0;
                r_cov[2] <= '0;
                r_cov[3] <= 48'sh1_0000_0000;
            end else if (i_cmd.wb) begin
                r_pos  <= n_pos;
                r_vel  <= n_vel;
                r_cov  <= n_cov;
                r_flag <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.prep) begin
            r_y <= w_y;
            r_s <= w_s;
        end
        if (i_cmd.wb) begin
            r_tmp <= n_tmp;
            r_tt  <= n_tt;
            r_u   <= n_u;
        end
        if (i_cmd.emit) begin
            r_out.position_estimate <= r_pos;
            r_out.velocity_estimate <= r_vel;
            r_out.saturated         <= r_flag;
        end
    end

    assign o_status.command   = r_in.command;
    assign o_status.s_zero    = (r_s == '0);
    assign o_status.unit_done = w_done;
    assign o_out_data         = r_out;

endmodule

`default_nettype wire

[src/kpvt_ctrl.sv]
// Tracker controller: handshakes on both channels and sequences the command steps.
// Drives kpvt_datapath through t_dp_cmd and reads t_dp_status. Uses kpvt_pkg.
`default_nettype none

module kpvt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire kpvt_pkg::t_dp_status i_status,
    output kpvt_pkg::t_dp_cmd  o_cmd
);
    import kpvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_CHECK, S_ISSUE, S_WAIT, S_FINISH
    } t_state;

    t_state r_state;
    t_step  r_step;
    logic   r_out_valid;

    logic w_accept;
    logic w_emit;
    logic w_last;

    always_comb begin
        w_accept    = i_in_valid && (r_state == S_IDLE);
        w_emit      = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
        w_last      = (r_step == ST_P7) || (r_step == ST_U6);
        o_cmd.load  = w_accept;
        o_cmd.init  = (r_state == S_DISPATCH) && (i_status.command == CMD_INIT);
        o_cmd.prep  = (r_state == S_DISPATCH) && (i_status.command == CMD_UPDATE);
        o_cmd.start = (r_state == S_ISSUE);
        o_cmd.wb    = (r_state == S_WAIT) && i_status.unit_done;
        o_cmd.emit  = w_emit;
        o_cmd.step  = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_P1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (i_status.command)
                        CMD_PREDICT: begin
                            r_step  <= ST_P1;
                            r_state <= S_ISSUE;
                        end
                        CMD_UPDATE: begin
                            r_state <= S_CHECK;
                        end
                        default: r_state <= S_FINISH;
                    endcase
                end
                S_CHECK: begin
                    if (i_status.s_zero) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_step  <= ST_U1;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_status.unit_done) begin
                        if (w_last) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_step  <= t_step'(r_step + 4'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/kalman_position_velocity_tracker.sv]
// Top level of the two-state constant-velocity tracker in fixed point.
// Joins kpvt_ctrl and kpvt_datapath (with kpvt_arith). Uses kpvt_pkg.
//
// One word in gives one word out; the input stalls from acceptance until the result is
// loaded into the output register. Predict runs seven products on the shared 64x16
// multiplier (issue, four 16-bit passes, round, finish, write back); update runs six
// divisions on the one-bit-per-cycle restoring divider (128 quotient steps plus the
// product and rounding); init and an unused command run no products, and an update
// with zero innovation variance skips the divisions. A full output register held by
// stall delays the loading of the result. A new word is taken while the previous
// result still waits in the output register.
`default_nettype none

module kalman_position_velocity_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kpvt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kpvt_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire kpvt_pkg::t_in_word             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output kpvt_pkg::t_out_word                 o_out_data
);
    import kpvt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    kpvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    kpvt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the position/velocity tracker: an in-bench fixed-point
// predictor computes each expected output word, compared field by field on accept.
// Depends on kpvt_pkg and kalman_position_velocity_tracker.
`default_nettype none

module tb;
    import kpvt_pkg::*;

    typedef logic signed [139:0] t_wide;

    localparam t_wide ONE_Q32  = t_wide'(1) <<< 32;
    localparam t_wide COV_MAXV = (t_wide'(1) <<< 47) - 1;
    localparam t_wide COV_MINV = -(t_wide'(1) <<< 47);
    localparam t_wide POS_MAXV = (t_wide'(1) <<< 31) - 1;
    localparam t_wide POS_MINV = -(t_wide'(1) <<< 31);
    localparam t_wide BIG_MAXV = t_wide'(1) <<< 62;
    localparam t_wide BIG_MINV = -(t_wide'(1) <<< 62);
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_data;

    kalman_position_velocity_tracker u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] reg_mirror [5];
    t_wide       trk_pos, trk_vel;
    t_wide       trk_cov [4];
    logic        clamp_hit;
    t_out_word   pending_words [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    int          hold_left = 0;

    function automatic t_wide clamp(t_wide v, t_wide lo, t_wide hi);
        if (v > hi) begin
            clamp_hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clamp_hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_wide mag(t_wide v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_wide mul_round(t_wide a, t_wide b, int sh, t_wide lo, t_wide hi);
        t_wide p;
        p = (mag(a) * mag(b) + (t_wide'(1) <<< (sh - 1))) >>> sh;
        return clamp(((a < 0) != (b < 0)) ? -p : p, lo, hi);
    endfunction

    function automatic t_wide mul_div(t_wide a, t_wide b, t_wide c);
        t_wide p;
        p = (mag(a) * mag(b) + (mag(c) >>> 1)) / mag(c);
        return clamp((((a < 0) != (b < 0)) != (c < 0)) ? -p : p, BIG_MINV, BIG_MAXV);
    endfunction

    task automatic track_predict(logic [23:0] step);
        t_wide t, q, a, b, c, d, dd, p00, p01, p10, s, tt, u;
        t = t_wide'(step);
        q = t_wide'(reg_mirror[REG_ACCEL_VAR]);
        a = trk_cov[0]; b = trk_cov[1]; c = trk_cov[2]; d = trk_cov[3];
        trk_pos = clamp(trk_pos + mul_round(trk_vel, t, 16, BIG_MINV, BIG_MAXV),
                        POS_MINV, POS_MAXV);
        dd  = mul_round(d, t, 16, COV_MINV, COV_MAXV);
        p01 = clamp(b + dd, COV_MINV, COV_MAXV);
        p10 = clamp(c + dd, COV_MINV, COV_MAXV);
        s   = clamp(p01 + c, COV_MINV, COV_MAXV);
        p00 = clamp(a + mul_round(s, t, 16, COV_MINV, COV_MAXV), COV_MINV, COV_MAXV);
        tt  = t * t;
        u   = mul_round(tt, q, 16, BIG_MINV, BIG_MAXV);
        trk_cov[0] = clamp(p00 + clamp(mul_round(u, tt, 34, BIG_MINV, BIG_MAXV),
                           COV_MINV, COV_MAXV), COV_MINV, COV_MAXV);
        s = clamp(mul_round(u, t, 17, BIG_MINV, BIG_MAXV), COV_MINV, COV_MAXV);
        trk_cov[1] = clamp(p01 + s, COV_MINV, COV_MAXV);
        trk_cov[2] = clamp(p10 + s, COV_MINV, COV_MAXV);
        trk_cov[3] = clamp(d + clamp(u, COV_MINV, COV_MAXV), COV_MINV, COV_MAXV);
    endtask

    task automatic track_update(logic signed [31:0] cam, logic signed [31:0] enc);
        t_wide z, r, s, y, a, b, c, d;
        z = (t_wide'(cam) + t_wide'(enc)) >>> 1;
        r = ((t_wide'(reg_mirror[REG_CAMERA_VAR]) + t_wide'(reg_mirror[REG_ENCODER_VAR]))
             >>> 1) <<< 16;
        a = trk_cov[0]; b = trk_cov[1]; c = trk_cov[2]; d = trk_cov[3];
        s = a + r;
        if (s == 0) return;
        y = z - trk_pos;
        trk_pos = clamp(trk_pos + mul_div(a, y, s), POS_MINV, POS_MAXV);
        trk_vel = clamp(trk_vel + mul_div(c, y, s), POS_MINV, POS_MAXV);
        trk_cov[0] = clamp(a - mul_div(a, a, s), COV_MINV, COV_MAXV);
        trk_cov[1] = clamp(b - mul_div(a, b, s), COV_MINV, COV_MAXV);
        trk_cov[2] = clamp(c - mul_div(c, a, s), COV_MINV, COV_MAXV);
        trk_cov[3] = clamp(d - mul_div(c, b, s), COV_MINV, COV_MAXV);
    endtask

    task automatic track_word(t_in_word w);
        t_out_word e;
        clamp_hit = 1'b0;
        case (w.command)
            CMD_INIT: begin
                trk_pos = t_wide'($signed(reg_mirror[REG_INIT_POS]));
                trk_vel = t_wide'($signed(reg_mirror[REG_INIT_VEL]));
                trk_cov = '{ONE_Q32, 0, 0, ONE_Q32};
            end
            CMD_PREDICT: track_predict(w.time_step);
            CMD_UPDATE:  track_update(w.cam_dist, w.enc_dist);
            default: ;
        endcase
        e.position_estimate = trk_pos[31:0];
        e.velocity_estimate = trk_vel[31:0];
        e.saturated = clamp_hit;
        pending_words.push_back(e);
    endtask

    task automatic send_word(t_in_word w);
        if (!calm && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        track_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_mirror[idx] = val;
    endtask

    task automatic write_all(logic [31:0] q, logic [31:0] cv, logic [31:0] ev,
                             logic [31:0] ip, logic [31:0] iv);
        write_reg(REG_ACCEL_VAR, q);
        write_reg(REG_CAMERA_VAR, cv);
        write_reg(REG_ENCODER_VAR, ev);
        write_reg(REG_INIT_POS, ip);
        write_reg(REG_INIT_VEL, iv);
        @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(logic [1:0] cmd, logic [23:0] dt,
                                           logic [31:0] cam, logic [31:0] enc);
        t_in_word w;
        w.command = cmd;
        w.time_step = dt;
        w.cam_dist = cam;
        w.enc_dist = enc;
        return w;
    endfunction

    function automatic t_in_word random_word();
        logic [31:0] near;
        int pick;
        pick = $urandom_range(99);
        near = trk_pos[31:0] + 32'($signed($urandom_range(8192)) - 4096) * 16;
        if (pick < 6)
            return make_word(CMD_INIT, 24'($urandom), $urandom, $urandom);
        if (pick < 9)
            return make_word(CMD_NONE, 24'($urandom), $urandom, $urandom);
        if (pick < 60)
            return make_word(CMD_PREDICT,
                             ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40000)),
                             $urandom, $urandom);
        if ($urandom_range(4) == 0)
            return make_word(CMD_UPDATE, 24'($urandom), $urandom, $urandom);
        return make_word(CMD_UPDATE, 24'($urandom),
                         near + 32'($urandom_range(65536)), near - 32'($urandom_range(65536)));
    endfunction

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 28);
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected output word %p", o_out_data);
                mismatches++;
            end else begin
                e = pending_words.pop_front();
                if (o_out_data.position_estimate !== e.position_estimate) begin
                    $error("position_estimate exp %0d got %0d",
                           e.position_estimate, o_out_data.position_estimate);
                    mismatches++;
                end
                if (o_out_data.velocity_estimate !== e.velocity_estimate) begin
                    $error("velocity_estimate exp %0d got %0d",
                           e.velocity_estimate, o_out_data.velocity_estimate);
                    mismatches++;
                end
                if (o_out_data.saturated !== e.saturated) begin
                    $error("saturated exp %0b got %0b", e.saturated, o_out_data.saturated);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed();
        send_word(make_word(CMD_UPDATE, 24'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_word(make_word(CMD_PREDICT, 24'h000000, 32'h80000000, 32'h80000000));
        send_word(make_word(CMD_UPDATE, 24'h000000, 32'h80000000, 32'h80000000));
        send_word(make_word(CMD_PREDICT, 24'h010000, 32'hFFFFFFFF, 32'h0));
        send_word(make_word(CMD_NONE, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_word(make_word(CMD_UPDATE, 24'h0, 32'hFFFFFFFF, 32'h0));
        drain();
        write_all(32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000);
        send_word(make_word(CMD_INIT, 24'h0, 32'h0, 32'h0));
        send_word(make_word(CMD_PREDICT, 24'hFFFFFF, 32'h0, 32'h0));
        send_word(make_word(CMD_INIT, 24'h0, 32'h0, 32'h0));
        // drive P00 to zero, then a zero-variance update
        send_word(make_word(CMD_UPDATE, 24'h0, 32'h00010000, 32'h00030000));
        send_word(make_word(CMD_UPDATE, 24'h0, 32'h7FFFFFFF, 32'h80000000));
        drain();
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_word(make_word(CMD_INIT, 24'h0, 32'h0, 32'h0));
        send_word(make_word(CMD_PREDICT, 24'hFFFFFF, 32'h0, 32'h0));
        send_word(make_word(CMD_PREDICT, 24'hFFFFFF, 32'h0, 32'h0));
        send_word(make_word(CMD_UPDATE, 24'h0, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_word(make_word(CMD_PREDICT, 24'h000001, 32'h0, 32'h0));
        send_word(make_word(CMD_UPDATE, 24'h0, 32'h80000000, 32'h80000000));
        drain();
    endtask

    task automatic test_random_phase(int count);
        write_all($urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(200000)),
                  $urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(100000)),
                  $urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(100000)),
                  $urandom, $urandom);
        send_word(make_word(CMD_INIT, 24'($urandom), $urandom, $urandom));
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3) && (n < count / 3 + 40);
            send_word(random_word());
        end
        calm = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        hold_left = 600;
        for (int n = 0; n < 16; n++)
            send_word(make_word(n % 3 == 0 ? CMD_INIT : CMD_PREDICT,
                                24'($urandom_range(20000)), $urandom, $urandom));
        drain();
    endtask

    initial begin
        reg_mirror = '{32'd65536, 32'd6554, 32'd13107, 32'd0, 32'd0};
        trk_pos = 0;
        trk_vel = 0;
        trk_cov = '{ONE_Q32, 0, 0, ONE_Q32};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        for (int p = 0; p < 4; p++)
            test_random_phase(203);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/kpvt_pkg.sv
src/kpvt_arith.sv
src/kpvt_datapath.sv
src/kpvt_ctrl.sv
src/kalman_position_velocity_tracker.sv
dv/tb.sv
